// ----- rtl/wsr_pkg.sv -----
`default_nettype none
package wsr_pkg;

    // fixed widths and limits of the sample and coefficient paths
    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 24;
    localparam int OUT_LIMIT = 64;
    localparam int OUT_CNT_W = 7;
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 18;
    localparam int IW_W      = 19;
    localparam int PROD_W    = 43;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_INTERP    = 3'd0,
        REG_HALF_TAPS = 3'd1,
        REG_STEP      = 3'd2,
        REG_CHANNELS  = 3'd3,
        REG_CENTER    = 3'd4
    } t_reg_idx;

    // register reset values
    localparam logic [7:0]  RST_INTERP   = 8'd120;
    localparam logic [5:0]  RST_HALF     = 6'd9;
    localparam logic [27:0] RST_STEP     = 28'd7864320;
    localparam logic [3:0]  RST_CHANNELS = 4'd1;
    localparam logic [12:0] RST_CENTER   = 13'd4096;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic setup;
        logic run_setup;
        logic calc;
        logic out_start;
        logic issue;
        logic result;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic frame_done;
        logic setup_done;
        logic emit_zero;
        logic issue_last;
        logic pipe_empty;
        logic out_free;
        logic last_out;
    } t_sts;

endpackage
`default_nettype wire

// ----- rtl/windowed_sinc_resampler_core.sv -----
`default_nettype none
// channel   valid          ready          payload
// input     i_in_valid     o_in_ready     i_kind i_sample_in i_coef_addr i_coef_value
// output    o_out_valid    i_out_ready    o_sample_out o_channel o_clipped o_overrun o_last
// config    i_cfg_valid    o_cfg_ready    i_cfg_index i_cfg_data
//
// table writes and samples that do not end a frame are taken without leaving idle
// a frame-ending sample starts a frame setup (phase divider and ring base walk), then
// each result is made of output start, one table/ring tap per cycle, pipeline
// drain and the result write
// ring reads as zero until written through a fill count: no clearing pass after reset
// a result waits in the output register while i_out_ready is low and holds the loop
module windowed_sinc_resampler_core #(
    parameter int RING_DEPTH    = 4096,
    parameter int TABLE_DEPTH   = 8192,
    parameter int MAX_HALF_TAPS = 32,
    parameter int MAX_CHANNELS  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [23:0] i_sample_in,
    input  logic [12:0]        i_coef_addr,
    input  logic signed [17:0] i_coef_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [23:0] o_sample_out,
    output logic [2:0]         o_channel,
    output logic               o_clipped,
    output logic               o_overrun,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [27:0]        i_cfg_data
);
    import wsr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    wsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wsr_dpath #(
        .RING_DEPTH    (RING_DEPTH),
        .TABLE_DEPTH   (TABLE_DEPTH),
        .MAX_HALF_TAPS (MAX_HALF_TAPS),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_sample_in  (i_sample_in),
        .i_coef_addr  (i_coef_addr),
        .i_coef_value (i_coef_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_channel    (o_channel),
        .o_clipped    (o_clipped),
        .o_overrun    (o_overrun),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// ----- rtl/wsr_ctrl.sv -----
`default_nettype none
module wsr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wsr_pkg::t_sts i_sts,
    output wsr_pkg::t_cmd o_cmd
);
    import wsr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_WAIT, S_CALC, S_OSTART, S_TAPS, S_DRAIN, S_RESULT
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_sts.frame_done) n_state = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.run_setup = 1'b1;
                if (i_sts.setup_done) n_state = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_sts.emit_zero ? S_IDLE : S_OSTART;
            end
            S_OSTART: begin
                o_cmd.out_start = 1'b1;
                n_state         = S_TAPS;
            end
            S_TAPS: begin
                o_cmd.issue = 1'b1;
                if (i_sts.issue_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = i_sts.last_out ? S_IDLE : S_OSTART;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/wsr_dpath.sv -----
`default_nettype none
module wsr_dpath #(
    parameter int RING_DEPTH    = 4096,
    parameter int TABLE_DEPTH   = 8192,
    parameter int MAX_HALF_TAPS = 32,
    parameter int MAX_CHANNELS  = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [2:0]          i_cfg_index,
    input  logic [27:0]         i_cfg_data,
    input  logic                i_kind,
    input  logic signed [23:0]  i_sample_in,
    input  logic [12:0]         i_coef_addr,
    input  logic signed [17:0]  i_coef_value,
    input  wsr_pkg::t_cmd       i_cmd,
    output wsr_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [23:0]  o_sample_out,
    output logic [2:0]          o_channel,
    output logic                o_clipped,
    output logic                o_overrun,
    output logic                o_last
);
    import wsr_pkg::*;

    localparam int RAW   = $clog2(RING_DEPTH);
    localparam int FW    = $clog2(RING_DEPTH + 1);
    localparam int TAW   = $clog2(TABLE_DEPTH);
    localparam int HW    = $clog2(MAX_HALF_TAPS + 1);
    localparam int TW    = $clog2(2 * MAX_HALF_TAPS + 3);
    localparam int CW    = $clog2(MAX_CHANNELS + 1);
    localparam int LHW   = 8 + HW;
    localparam int PW    = ((LHW + 1 > 14) ? LHW + 1 : 14) + 2;
    localparam int ACC_W = PROD_W + TW;
    localparam logic [RAW:0] RD_EXT = (RAW + 1)'(RING_DEPTH);
    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(8388607);
    localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-8388608);

    // configuration registers
    logic [7:0]  r_interp;
    logic [5:0]  r_half;
    logic [27:0] r_step;
    logic [3:0]  r_nch_cfg;
    logic [12:0] r_center;

    // stream state
    logic [27:0]   r_phase;
    logic [RAW-1:0] r_wp;
    logic [FW-1:0] r_fill;
    logic [CW-1:0] r_chan;

    // frame setup
    logic                r_pre;
    logic [DIV_BITS-1:0] r_dq;
    logic [27:0]         r_drem;
    logic [4:0]          r_dcnt;
    logic [RAW-1:0]      r_base;
    logic [TW-1:0]       r_bcnt;
    logic [LHW-1:0]      r_lh;

    // output loop
    logic [OUT_CNT_W-1:0] r_emit, r_n;
    logic                 r_over;
    logic [28:0]          r_ph;
    logic [CW-1:0]        r_c;

    // tap issue
    logic signed [PW-1:0] r_pos;
    logic [RAW-1:0]       r_raddr;
    logic [TW-1:0]        r_tapcnt;

    // tap pipeline
    logic                     r_v1, r_v2, r_v3;
    logic                     r_ina, r_inb, r_inx;
    logic signed [COEF_W-1:0] r_adata, r_bdata, r_a2;
    logic signed [SAMPLE_W-1:0] r_xdata, r_x2;
    logic signed [35:0]       r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [ACC_W-1:0]  r_acc;

    // result register
    logic                r_out_valid;
    logic signed [23:0]  r_out_sample;
    logic [2:0]          r_out_chan;
    logic                r_out_clip, r_out_over, r_out_last;

    // memories
    logic signed [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic signed [COEF_W-1:0]   r_tbl  [TABLE_DEPTH];

    // effective register values
    logic [7:0]     eff_l;
    logic [HW-1:0]  eff_h;
    logic [CW-1:0]  eff_nch;
    logic [27:0]    eff_st;
    logic [23:0]    lq;
    logic [TW-1:0]  taps;

    always_comb begin
        eff_l  = (r_interp == 8'd0) ? 8'd1 : r_interp;
        eff_st = (r_step == 28'd0) ? 28'd1 : r_step;
        if (r_half == 6'd0) eff_h = HW'(1);
        else if (32'(r_half) > MAX_HALF_TAPS) eff_h = HW'(MAX_HALF_TAPS);
        else eff_h = HW'(r_half);
        if (r_nch_cfg == 4'd0) eff_nch = CW'(1);
        else if (32'(r_nch_cfg) > MAX_CHANNELS) eff_nch = CW'(MAX_CHANNELS);
        else eff_nch = CW'(r_nch_cfg);
        lq   = {eff_l, 16'd0};
        taps = TW'({eff_h, 1'b0}) + TW'(2);
    end

    // input side decode
    logic          tbl_wr_ok;
    logic [CW-1:0] chan_inc;
    assign tbl_wr_ok = (32'(i_coef_addr) < TABLE_DEPTH);
    assign chan_inc  = CW'(r_chan + 1'b1);

    // divider step
    logic [28:0] div_tmp;
    logic        div_ge;
    assign div_tmp = {r_drem, r_dq[DIV_BITS-1]};
    assign div_ge  = (div_tmp >= {1'b0, eff_st});

    // base address step (back by one frame)
    logic [RAW:0] base_tmp, base_nxt;
    always_comb begin
        base_tmp = {1'b0, r_base} + RD_EXT - (RAW + 1)'(eff_nch);
        base_nxt = (base_tmp >= RD_EXT) ? base_tmp - RD_EXT : base_tmp;
    end

    // frame totals
    logic [24:0]      k_val;
    logic [24+CW:0]   total;
    logic [27:0]      new_phase;
    logic             over_now;
    always_comb begin
        k_val = r_pre ? ({1'b0, r_dq} + 25'(r_drem != 28'd0)) : 25'd0;
        total = (25 + CW)'(k_val) * (25 + CW)'(eff_nch);
        over_now = (total > (25 + CW)'(OUT_LIMIT));
        if (r_pre) new_phase = (r_drem == 28'd0) ? 28'd0 : eff_st - r_drem;
        else new_phase = r_phase - {4'd0, lq};
    end

    // per-output start values
    logic signed [PW-1:0] pos_start;
    logic [RAW:0]         ra_tmp, ra_start, rn_tmp, ra_nxt;
    always_comb begin
        pos_start = PW'($signed({1'b0, r_center})) - PW'($signed({1'b0, r_lh}))
                  - PW'($signed({1'b0, r_ph[23:16]}));
        ra_tmp   = {1'b0, r_base} + (RAW + 1)'(r_c);
        ra_start = (ra_tmp >= RD_EXT) ? ra_tmp - RD_EXT : ra_tmp;
        rn_tmp   = {1'b0, r_raddr} + (RAW + 1)'(eff_nch);
        ra_nxt   = (rn_tmp >= RD_EXT) ? rn_tmp - RD_EXT : rn_tmp;
    end

    // table range checks and indexes
    logic signed [PW-1:0] pos_b;
    logic                 ina, inb, inx;
    assign pos_b = r_pos - PW'(1);
    assign ina   = (r_pos >= 0) && (int'(r_pos) < TABLE_DEPTH);
    assign inb   = (pos_b >= 0) && (int'(pos_b) < TABLE_DEPTH);
    assign inx   = (FW'(r_raddr) < r_fill);

    // interpolation and products
    logic signed [COEF_W-1:0]   a_s, b_s;
    logic signed [SAMPLE_W-1:0] x_s;
    logic signed [18:0]         diff;
    logic signed [36:0]         iw_full;
    logic signed [IW_W-1:0]     iw;
    always_comb begin
        a_s     = r_ina ? r_adata : '0;
        b_s     = r_inb ? r_bdata : '0;
        x_s     = r_inx ? r_xdata : '0;
        diff    = 19'(b_s) - 19'(a_s);
        iw_full = (37'(r_a2) <<< FRAC_BITS) + 37'(r_p1) + 37'sd32768;
        iw      = iw_full[34:16];
    end

    // rounding and saturation
    logic signed [ACC_W-1:0] y_sum, y_sh;
    logic signed [23:0]      y_out;
    logic                    y_clip;
    always_comb begin
        y_sum = r_acc + ACC_W'(32768);
        y_sh  = y_sum >>> FRAC_BITS;
        if (y_sh > Y_MAX) begin
            y_out  = 24'sh7FFFFF;
            y_clip = 1'b1;
        end else if (y_sh < Y_MIN) begin
            y_out  = -24'sh800000;
            y_clip = 1'b1;
        end else begin
            y_out  = y_sh[23:0];
            y_clip = 1'b0;
        end
    end

    logic last_now;
    assign last_now = (OUT_CNT_W'(r_n + 1'b1) == r_emit);

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_kind) r_ring[r_wp] <= i_sample_in;
        if (i_cmd.issue) r_xdata <= r_ring[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_kind && tbl_wr_ok) r_tbl[TAW'(i_coef_addr)] <= i_coef_value;
        if (i_cmd.issue) begin
            r_adata <= r_tbl[TAW'(r_pos)];
            r_bdata <= r_tbl[TAW'(pos_b)];
        end
    end

    // datapath payload registers
    always_ff @(posedge i_clk) begin
        r_ina <= ina;
        r_inb <= inb;
        r_inx <= inx;
        r_p1  <= $signed({1'b0, r_ph[15:0]}) * diff;
        r_a2  <= a_s;
        r_x2  <= x_s;
        r_p2  <= iw * r_x2;
        if (i_cmd.out_start) r_acc <= '0;
        else if (r_v3) r_acc <= r_acc + ACC_W'(r_p2);
        if (i_cmd.setup) begin
            r_pre  <= ({4'd0, lq} > r_phase);
            r_dq   <= lq - r_phase[23:0];
            r_drem <= '0;
            r_base <= r_wp;
            r_lh   <= LHW'(eff_l) * LHW'(eff_h);
        end else if (i_cmd.run_setup) begin
            if (r_dcnt != 5'd0) begin
                r_dq   <= {r_dq[DIV_BITS-2:0], div_ge};
                r_drem <= div_ge ? 28'(div_tmp - {1'b0, eff_st}) : div_tmp[27:0];
            end
            if (r_bcnt != '0) r_base <= base_nxt[RAW-1:0];
        end
        if (i_cmd.calc) begin
            r_emit <= over_now ? OUT_CNT_W'(OUT_LIMIT) : OUT_CNT_W'(total);
            r_over <= over_now;
            r_ph   <= {1'b0, r_phase};
        end else if (i_cmd.result && (CW'(r_c + 1'b1) == eff_nch)) begin
            r_ph <= r_ph + {1'b0, eff_st};
        end
        if (i_cmd.out_start) begin
            r_pos   <= pos_start;
            r_raddr <= ra_start[RAW-1:0];
        end else if (i_cmd.issue) begin
            r_pos   <= r_pos + PW'($signed({1'b0, eff_l}));
            r_raddr <= ra_nxt[RAW-1:0];
        end
        if (i_cmd.result) begin
            r_out_sample <= y_out;
            r_out_chan   <= 3'(r_c);
            r_out_clip   <= y_clip;
            r_out_over   <= r_over;
            r_out_last   <= last_now;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp    <= RST_INTERP;
            r_half      <= RST_HALF;
            r_step      <= RST_STEP;
            r_nch_cfg   <= RST_CHANNELS;
            r_center    <= RST_CENTER;
            r_phase     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_chan      <= '0;
            r_dcnt      <= '0;
            r_bcnt      <= '0;
            r_n         <= '0;
            r_c         <= '0;
            r_tapcnt    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_INTERP:    r_interp  <= i_cfg_data[7:0];
                    REG_HALF_TAPS: r_half    <= i_cfg_data[5:0];
                    REG_STEP:      r_step    <= i_cfg_data;
                    REG_CHANNELS:  r_nch_cfg <= i_cfg_data[3:0];
                    REG_CENTER:    r_center  <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            // sample beat into the ring
            if (i_cmd.accept && !i_kind) begin
                r_wp   <= (32'(r_wp) == RING_DEPTH - 1) ? '0 : RAW'(r_wp + 1'b1);
                r_fill <= (32'(r_fill) == RING_DEPTH) ? r_fill : FW'(r_fill + 1'b1);
                r_chan <= (chan_inc >= eff_nch) ? '0 : chan_inc;
            end
            // frame setup counters
            if (i_cmd.setup) begin
                r_dcnt <= ({4'd0, lq} > r_phase) ? 5'(DIV_BITS) : 5'd0;
                r_bcnt <= taps;
            end else if (i_cmd.run_setup) begin
                if (r_dcnt != 5'd0) r_dcnt <= r_dcnt - 5'd1;
                if (r_bcnt != '0) r_bcnt <= r_bcnt - 1'b1;
            end
            if (i_cmd.calc) begin
                r_phase <= new_phase;
                r_n     <= '0;
                r_c     <= '0;
            end
            // tap issue
            if (i_cmd.out_start) r_tapcnt <= taps;
            else if (i_cmd.issue) r_tapcnt <= r_tapcnt - 1'b1;
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            // output loop counters
            if (i_cmd.result) begin
                r_n <= OUT_CNT_W'(r_n + 1'b1);
                r_c <= (CW'(r_c + 1'b1) == eff_nch) ? '0 : CW'(r_c + 1'b1);
            end
            // result register
            if (i_cmd.result) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // status
    always_comb begin
        o_sts            = '0;
        o_sts.frame_done = !i_kind && (chan_inc >= eff_nch);
        o_sts.setup_done = (r_dcnt == 5'd0) && (r_bcnt == '0);
        o_sts.emit_zero  = (total == '0);
        o_sts.issue_last = (r_tapcnt == TW'(1));
        o_sts.pipe_empty = !r_v1 && !r_v2 && !r_v3;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.last_out   = last_now;
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_channel    = r_out_chan;
    assign o_clipped    = r_out_clip;
    assign o_overrun    = r_out_over;
    assign o_last       = r_out_last;

    // a result is only written when the output register can take it
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.result |-> (!r_out_valid || i_out_ready))
        else $error("result written over a held beat");

    // a new output starts with an empty tap pipeline
    a_pipe_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_start |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("tap pipeline busy at output start");

    // the last result of a frame closes the count
    a_count_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.result && last_now) |=> (r_n == r_emit))
        else $error("result count mismatch");

endmodule
`default_nettype wire
